>>> sv/bpk_pkg.sv
`timescale 1ns / 1ps

package bpk_pkg;

  // Widest field the packer takes, used as the default of the top-level parameter.
  localparam int MAX_FIELD_BITS_DEF = 64;

  // Width of the bit count field of an input item.
  localparam int COUNT_W = 7;

  // Width of a packed output byte and of its valid-bit count.
  localparam int BYTE_W = 8;
  localparam int VB_W   = 4;

  // Valid-bit code of a completed byte.
  localparam logic [VB_W-1:0] VB_FULL = 4'd8;

  // Entries in the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

endpackage

>>> sv/bpk_front.sv
`timescale 1ns / 1ps

module bpk_front
  import bpk_pkg::*;
#(
  parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF,
  parameter int IN_W = ((MAX_FIELD_BITS + COUNT_W + 7) / 8) * 8,
  parameter int EW = MAX_FIELD_BITS + COUNT_W + 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [IN_W-1:0] s_tdata,
  input  logic            s_tlast,
  output logic            f_valid,
  input  logic            f_ready,
  output logic [EW-1:0]   f_data
);

  typedef struct packed {
    logic                      err;
    logic                      flush;
    logic [COUNT_W-1:0]        count;
    logic [MAX_FIELD_BITS-1:0] value;
  } entry_t;

  logic [MAX_FIELD_BITS-1:0] in_value;
  logic [COUNT_W-1:0]        in_count;
  logic [MAX_FIELD_BITS-1:0] mask;
  entry_t                    entry_in;
  entry_t                    entry;
  logic                      accept;

  assign in_value = s_tdata[MAX_FIELD_BITS-1:0];
  assign in_count = s_tdata[MAX_FIELD_BITS +: COUNT_W];

  // A shift by the full width or more leaves no ones, so the mask covers every bit then.
  assign mask = ~({MAX_FIELD_BITS{1'b1}} << in_count);

  always_comb begin
    entry_in.err   = in_count > COUNT_W'(MAX_FIELD_BITS);
    entry_in.flush = s_tlast;
    entry_in.count = in_count;
    entry_in.value = in_value & mask;
  end

  assign s_tready = !f_valid || f_ready;
  assign accept   = s_tvalid && s_tready;
  assign f_data   = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (f_ready) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entry <= entry_in;
    end
  end

endmodule

>>> sv/bpk_queue.sv
`timescale 1ns / 1ps

module bpk_queue
  import bpk_pkg::*;
#(
  parameter int EW = MAX_FIELD_BITS_DEF + COUNT_W + 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [EW-1:0] in_data,
  output logic          out_valid,
  input  logic          out_pop,
  output logic [EW-1:0] out_data
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [EW-1:0] slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic          push;
  logic          pop;

  assign in_ready  = fill != CW'(QUEUE_DEPTH);
  assign out_valid = fill != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_pop && out_valid;
  assign out_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

endmodule

>>> sv/bpk_back.sv
`timescale 1ns / 1ps

module bpk_back
  import bpk_pkg::*;
#(
  parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF,
  parameter int EW = MAX_FIELD_BITS + COUNT_W + 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_pop,
  input  logic [EW-1:0] q_data,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [15:0]   m_tdata,
  output logic          m_tlast,
  output logic          m_tuser
);

  localparam int AW = MAX_FIELD_BITS + BYTE_W;
  localparam int RW = $clog2(AW + 1);

  typedef struct packed {
    logic                      err;
    logic                      flush;
    logic [COUNT_W-1:0]        count;
    logic [MAX_FIELD_BITS-1:0] value;
  } entry_t;

  entry_t          head;
  logic            busy, busy_next, post_busy;
  logic            err_q, err_next, post_err;
  logic            flush_q, flush_next;
  logic [AW-1:0]   acc, acc_next, post_acc;
  logic [RW-1:0]   rem, rem_next, post_rem;
  logic [RW-1:0]   rem8, total, shamt;
  logic            more, has_results;
  logic            out_free, emit, pop;
  logic [BYTE_W-1:0] e_byte, out_byte;
  logic [VB_W-1:0]   e_vb, out_vb;
  logic            e_last, e_err;
  logic            out_valid, out_last, out_err;

  assign head     = q_data;
  assign out_free = !out_valid || m_tready;
  assign emit     = busy && out_free;

  always_comb begin
    post_busy = busy;
    post_err  = err_q;
    post_acc  = acc;
    post_rem  = rem;
    rem8      = rem - RW'(8);
    more      = 1'b0;
    e_byte    = acc[AW-1 -: BYTE_W];
    e_vb      = VB_FULL;
    e_last    = 1'b0;
    e_err     = 1'b0;
    if (emit) begin
      if (err_q) begin
        e_byte    = '0;
        e_vb      = '0;
        e_last    = 1'b1;
        e_err     = 1'b1;
        post_busy = 1'b0;
        post_err  = 1'b0;
      end else if (rem >= RW'(8)) begin
        more      = (rem8 >= RW'(8)) || (flush_q && (rem8 != '0));
        e_last    = !more;
        post_acc  = acc << BYTE_W;
        post_rem  = rem8;
        post_busy = more;
      end else begin
        e_vb      = VB_W'(rem);
        e_last    = 1'b1;
        post_acc  = '0;
        post_rem  = '0;
        post_busy = 1'b0;
      end
    end

    // The next entry loads in the same cycle as the last byte of the current one.
    pop         = !post_busy && q_valid;
    total       = post_rem + RW'(head.count);
    shamt       = RW'(AW) - total;
    has_results = (total >= RW'(8)) || (head.flush && (total != '0));
    busy_next   = post_busy;
    err_next    = post_err;
    flush_next  = flush_q;
    acc_next    = post_acc;
    rem_next    = post_rem;
    if (pop) begin
      if (head.err) begin
        busy_next = 1'b1;
        err_next  = 1'b1;
      end else begin
        busy_next  = has_results;
        err_next   = 1'b0;
        flush_next = head.flush;
        acc_next   = post_acc | ({{BYTE_W{1'b0}}, head.value} << shamt);
        rem_next   = total;
        if (!has_results && head.flush) begin
          acc_next = '0;
          rem_next = '0;
        end
      end
    end
  end

  assign q_pop = pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      err_q     <= 1'b0;
      flush_q   <= 1'b0;
      acc       <= '0;
      rem       <= '0;
      out_valid <= 1'b0;
    end else begin
      busy    <= busy_next;
      err_q   <= err_next;
      flush_q <= flush_next;
      acc     <= acc_next;
      rem     <= rem_next;
      if (out_free) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= e_byte;
      out_vb   <= e_vb;
      out_last <= e_last;
      out_err  <= e_err;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(16 - BYTE_W - VB_W){1'b0}}, out_vb, out_byte};
  assign m_tlast  = out_last;
  assign m_tuser  = out_err;

`ifndef SYNTH
  a_idle_partial: assert property (@(posedge clk) disable iff (rst)
    !busy |-> rem < RW'(8))
    else $error("idle with a full byte still held");

  a_err_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_err |-> (out_vb == '0) && out_last && (out_byte == '0))
    else $error("malformed error result");

  a_inner_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> (out_vb == VB_FULL) && !out_err)
    else $error("partial byte emitted before the end of a run");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !(busy && !emit))
    else $error("queue popped while a stalled entry is in progress");
`endif

endmodule

>>> sv/msb_first_bit_packer_core.sv
// MSB-first variable-length bit packer.
// Input channel s_*: each item carries a field value and a bit count of 0 to
// MAX_FIELD_BITS; its low bits are appended to the stream, most significant first.
// s_tlast set on an item flushes the partially filled byte, padded with zeros.
// Output channel m_*: one item per packed byte, first stream bit in bit 7, with
// the count of meaningful bits; m_tlast marks the final byte caused by one input.
// A count above MAX_FIELD_BITS gives one error item (m_tuser set) and appends nothing.
// With the engine idle, the first byte of an accepted input item passes a front
// register, a two-entry queue and the byte engine with its output register before
// it shows on m_tvalid.
// The byte engine emits one byte per cycle while the receiver takes them, and it
// loads the next item in the cycle in which it emits the last byte of the current one.
// Items that produce no byte do not hold the engine busy.
// Reset clears the partial byte, its fill count, the queue and the output.
// When the receiver stalls, the output item holds, the engine, the queue and then the
// front register fill, and s_tready drops only once all of them are full.

`timescale 1ns / 1ps

module msb_first_bit_packer_core
  import bpk_pkg::*;
#(
  parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // Fields from bit 0 up: value, bit_count, zero padding.
  input  logic [((MAX_FIELD_BITS + COUNT_W + 7) / 8) * 8 - 1:0] s_tdata,
  // flush
  input  logic s_tlast,
  output logic m_tvalid,
  input  logic m_tready,
  // Fields from bit 0 up: out_byte, valid_bits, zero padding.
  output logic [15:0] m_tdata,
  // last_of_run
  output logic m_tlast,
  // error
  output logic m_tuser
);

  localparam int EW = MAX_FIELD_BITS + COUNT_W + 2;

  logic          f_valid;
  logic          f_ready;
  logic [EW-1:0] f_data;
  logic          q_valid;
  logic          q_pop;
  logic [EW-1:0] q_data;

  // Front part: takes items in and classifies them (error check, value masking).
  bpk_front #(
    .MAX_FIELD_BITS(MAX_FIELD_BITS),
    .EW(EW)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .f_valid (f_valid),
    .f_ready (f_ready),
    .f_data  (f_data)
  );

  // Short queue so that the front keeps accepting while the engine is busy.
  bpk_queue #(
    .EW(EW)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .in_ready (f_ready),
    .in_data  (f_data),
    .out_valid(q_valid),
    .out_pop  (q_pop),
    .out_data (q_data)
  );

  // Back part: holds the partial byte and emits one packed byte per cycle while m_tready allows.
  bpk_back #(
    .MAX_FIELD_BITS(MAX_FIELD_BITS),
    .EW(EW)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_data  (q_data),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

endmodule
